// ===== design/rstat_pkg.sv =====
package rstat_pkg;

  // Field widths of the channels and the configuration register
  localparam int ELAPSED_W = 32;
  localparam int TARGET_W  = 32;
  localparam int TOTAL_W   = 16;
  localparam int ERR_W     = 33;
  localparam int SD_W      = 32;

  // Number formats of the running statistics
  localparam int MEAN_FRACTION_BITS = 16;
  localparam int COUNT_BITS         = 16;
  localparam int MEAN_W             = ELAPSED_W + MEAN_FRACTION_BITS;

  // Shared adder and work register sizes
  localparam int ALU_W       = 64;
  localparam int SQRT_STEPS  = ALU_W / 2;
  localparam int ACC_W       = (MEAN_W + 1 > SQRT_STEPS + 3) ? MEAN_W + 1 : SQRT_STEPS + 3;
  localparam int ITER_W      = 6;

  // Min/max seeds: most positive and most negative error
  localparam logic [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

// ===== design/rstat_in_if.sv =====
interface rstat_in_if import rstat_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed_ns;
  logic                 first_of_series;

  modport source (output valid, output elapsed_ns, output first_of_series, input ready);
  modport sink   (input valid, input elapsed_ns, input first_of_series, output ready);

endinterface

// ===== design/rstat_out_if.sv =====
interface rstat_out_if import rstat_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic [TOTAL_W-1:0]       sample_total;
  logic signed [ERR_W-1:0]  mean_error_ns;
  logic [SD_W-1:0]          stddev_ns;
  logic signed [ERR_W-1:0]  min_error_ns;
  logic signed [ERR_W-1:0]  max_error_ns;

  modport source (output valid, output sample_total, output mean_error_ns, output stddev_ns,
                  output min_error_ns, output max_error_ns, input ready);
  modport sink   (input valid, input sample_total, input mean_error_ns, input stddev_ns,
                  input min_error_ns, input max_error_ns, output ready);

endinterface

// ===== design/rstat_alu.sv =====
module rstat_alu import rstat_pkg::*; (
  input  alu_op_t          op,
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output logic [ALU_W-1:0] res,
  output logic             carry
);

  logic [ALU_W-1:0] b_eff;
  logic [ALU_W:0]   full;

  // a + b, or a - b as a + ~b + 1; carry set on subtract means a >= b
  assign b_eff = (op == ALU_SUB) ? ~b : b;
  assign full  = {1'b0, a} + {1'b0, b_eff} + (ALU_W+1)'(op == ALU_SUB);
  assign res   = full[ALU_W-1:0];
  assign carry = full[ALU_W];

endmodule

// ===== design/running_error_statistics.sv =====
// Transactions are taken one at a time: in_ch.ready is high only in the idle state, and the
// sequencer waits in S_DONE while the previous result still waits in the output register.
// The variance divide and square root are skipped while the series holds under two samples.
// Every step goes through one shared 64-bit adder (bit-serial divides, shift-add multiply,
// two-bit-per-step square root).
// Reset (rst, synchronous): statistics cleared, target_ns = 0, no result pending.
module running_error_statistics import rstat_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [TARGET_W-1:0] cfg_wdata,
  rstat_in_if.sink            in_ch,
  rstat_out_if.source         out_ch
);

  localparam int F      = MEAN_FRACTION_BITS;
  localparam int CB     = COUNT_BITS;
  localparam int TCMP_W = (CB > TOTAL_W) ? CB : TOTAL_W;

  typedef enum logic [4:0] {
    S_IDLE, S_DELTA, S_DNEG, S_QDIV, S_MEAN, S_EPOS, S_ENEG, S_MUL, S_M2,
    S_ERR, S_MIN, S_MAX, S_MDIFF, S_MRND, S_VDIV, S_SQRT, S_DONE
  } state_t;

  state_t               state;
  logic [TARGET_W-1:0]  target;
  logic [CB-1:0]        count;
  logic [MEAN_W-1:0]    mean;
  logic [ALU_W-1:0]     m2;
  logic [ERR_W-1:0]     lowest;
  logic [ERR_W-1:0]     highest;
  logic [ELAPSED_W-1:0] elapsed;
  logic [ERR_W-1:0]     err;
  logic [ERR_W-1:0]     mean_err;
  logic [MEAN_W-1:0]    mag_d;
  logic                 neg_d;
  logic [ALU_W-1:0]     wa;
  logic [ACC_W-1:0]     acc;
  logic [CB-1:0]        dv;
  logic [SD_W-1:0]      root;
  logic [ITER_W-1:0]    iter;

  alu_op_t              op;
  logic [ALU_W-1:0]     opa;
  logic [ALU_W-1:0]     opb;
  logic [ALU_W-1:0]     res;
  logic                 carry;

  logic [MEAN_W-1:0]    x;
  logic [MEAN_W-1:0]    target_fx;
  logic [CB:0]          div_shift;
  logic [ACC_W-1:0]     mul_sum;
  logic [ACC_W-1:0]     sq_shift;
  logic [2*MEAN_W-1:0]  prod_full;
  logic [ALU_W-1:0]     prod;
  logic [TCMP_W-1:0]    count_wide;
  logic [TOTAL_W-1:0]   total;
  logic                 take_in;

  rstat_alu u_alu (
    .op    (op),
    .a     (opa),
    .b     (opb),
    .res   (res),
    .carry (carry)
  );

  // Fixed-point views and step operands
  assign x         = MEAN_W'(elapsed) << F;
  assign target_fx = MEAN_W'(target) << F;
  assign div_shift = {acc[CB-1:0], wa[ALU_W-1]};
  assign mul_sum   = wa[0] ? res[ACC_W-1:0] : acc;
  assign sq_shift  = {acc[ACC_W-3:0], wa[ALU_W-1 -: 2]};
  assign prod_full = {acc[MEAN_W-1:0], wa[ALU_W-1 -: MEAN_W]};
  assign prod      = prod_full[2*MEAN_W-1 : 2*F];

  // Count shown saturated to the output width
  assign count_wide = TCMP_W'(count);
  assign total      = (count_wide > TCMP_W'({TOTAL_W{1'b1}})) ? {TOTAL_W{1'b1}}
                                                              : count_wide[TOTAL_W-1:0];

  assign in_ch.ready = (state == S_IDLE);
  assign take_in     = in_ch.valid && in_ch.ready;

  // Operand select for the shared adder
  always_comb begin
    op  = ALU_ADD;
    opa = '0;
    opb = '0;
    unique case (state)
      S_DELTA, S_EPOS: begin
        op  = ALU_SUB;
        opa = ALU_W'(x);
        opb = ALU_W'(mean);
      end
      S_DNEG, S_ENEG: begin
        op  = ALU_SUB;
        opa = ALU_W'(mean);
        opb = ALU_W'(x);
      end
      S_QDIV, S_VDIV: begin
        op  = ALU_SUB;
        opa = ALU_W'(div_shift);
        opb = ALU_W'(dv);
      end
      S_MEAN: begin
        op  = neg_d ? ALU_SUB : ALU_ADD;
        opa = ALU_W'(mean);
        opb = ALU_W'(wa[MEAN_W-1:0]);
      end
      S_MUL: begin
        opa = ALU_W'(acc);
        opb = ALU_W'(mag_d);
      end
      S_M2: begin
        opa = m2;
        opb = prod;
      end
      S_ERR: begin
        op  = ALU_SUB;
        opa = ALU_W'(elapsed);
        opb = ALU_W'(target);
      end
      S_MIN: begin
        op  = ALU_SUB;
        opa = {{(ALU_W-ERR_W){err[ERR_W-1]}}, err};
        opb = {{(ALU_W-ERR_W){lowest[ERR_W-1]}}, lowest};
      end
      S_MAX: begin
        op  = ALU_SUB;
        opa = {{(ALU_W-ERR_W){highest[ERR_W-1]}}, highest};
        opb = {{(ALU_W-ERR_W){err[ERR_W-1]}}, err};
      end
      S_MDIFF: begin
        op  = ALU_SUB;
        opa = ALU_W'(mean);
        opb = ALU_W'(target_fx);
      end
      S_MRND: begin
        opa = wa;
        opb = ALU_W'({F{1'b1}});
      end
      S_SQRT: begin
        op  = ALU_SUB;
        opa = ALU_W'(sq_shift);
        opb = ALU_W'({root, 2'b01});
      end
      default: begin
        op  = ALU_ADD;
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Sequencer, statistics and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_ch.valid <= 1'b0;
      target       <= '0;
      count        <= '0;
      mean         <= '0;
      m2           <= '0;
      lowest       <= ERR_MAX;
      highest      <= ERR_MIN;
    end else begin
      if (cfg_we) begin
        target <= cfg_wdata;
      end
      // S_DONE reloads the output register itself
      if (out_ch.valid && out_ch.ready && state != S_DONE) begin
        out_ch.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (take_in) begin
            elapsed <= in_ch.elapsed_ns;
            if (in_ch.first_of_series) begin
              count   <= CB'(1);
              mean    <= '0;
              m2      <= '0;
              lowest  <= ERR_MAX;
              highest <= ERR_MIN;
            end else if (count != {CB{1'b1}}) begin
              count <= count + CB'(1);
            end
            state <= S_DELTA;
          end
        end

        // delta = x - mean, kept as sign and magnitude
        S_DELTA, S_DNEG: begin
          if (state == S_DELTA && !carry) begin
            neg_d <= 1'b1;
            state <= S_DNEG;
          end else begin
            if (state == S_DELTA) begin
              neg_d <= 1'b0;
            end
            mag_d <= res[MEAN_W-1:0];
            wa    <= ALU_W'(res[MEAN_W-1:0]) << (ALU_W - MEAN_W);
            acc   <= '0;
            dv    <= count;
            iter  <= ITER_W'(MEAN_W - 1);
            state <= S_QDIV;
          end
        end

        // Restoring divide, one quotient bit per cycle
        S_QDIV, S_VDIV: begin
          wa <= {wa[ALU_W-2:0], carry};
          if (iter == '0 && state == S_VDIV) begin
            acc   <= '0;
            root  <= '0;
            iter  <= ITER_W'(SQRT_STEPS - 1);
            state <= S_SQRT;
          end else begin
            acc  <= ACC_W'(carry ? res[CB-1:0] : div_shift[CB-1:0]);
            iter <= iter - ITER_W'(1);
            if (iter == '0) begin
              state <= S_MEAN;
            end
          end
        end

        S_MEAN: begin
          mean  <= res[MEAN_W-1:0];
          state <= S_EPOS;
        end

        // |x - new mean| becomes the multiplier
        S_EPOS, S_ENEG: begin
          if (state == S_EPOS && !carry) begin
            state <= S_ENEG;
          end else begin
            wa    <= ALU_W'(res[MEAN_W-1:0]);
            acc   <= '0;
            iter  <= ITER_W'(MEAN_W - 1);
            state <= S_MUL;
          end
        end

        // Shift-add multiply, LSB first; product ends in {acc, wa top}
        S_MUL: begin
          acc  <= mul_sum >> 1;
          wa   <= {mul_sum[0], wa[ALU_W-1:1]};
          iter <= iter - ITER_W'(1);
          if (iter == '0) begin
            state <= S_M2;
          end
        end

        S_M2: begin
          m2    <= carry ? {ALU_W{1'b1}} : res;
          state <= S_ERR;
        end

        S_ERR: begin
          err   <= res[ERR_W-1:0];
          state <= S_MIN;
        end

        S_MIN: begin
          if (res[ALU_W-1]) begin
            lowest <= err;
          end
          state <= S_MAX;
        end

        S_MAX: begin
          if (res[ALU_W-1]) begin
            highest <= err;
          end
          state <= S_MDIFF;
        end

        // Mean error truncated toward zero: negative diff is biased before the shift
        S_MDIFF, S_MRND: begin
          if (state == S_MDIFF && res[ALU_W-1]) begin
            wa    <= res;
            state <= S_MRND;
          end else begin
            mean_err <= res[F +: ERR_W];
            if (count > CB'(1)) begin
              dv    <= count - CB'(1);
              wa    <= m2;
              acc   <= '0;
              iter  <= ITER_W'(ALU_W - 1);
              state <= S_VDIV;
            end else begin
              root  <= '0;
              state <= S_DONE;
            end
          end
        end

        // Integer square root, two radicand bits per cycle
        S_SQRT: begin
          if (carry) begin
            acc  <= res[ACC_W-1:0];
            root <= {root[SD_W-2:0], 1'b1};
          end else begin
            acc  <= sq_shift;
            root <= {root[SD_W-2:0], 1'b0};
          end
          wa   <= wa << 2;
          iter <= iter - ITER_W'(1);
          if (iter == '0) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid         <= 1'b1;
            out_ch.sample_total  <= total;
            out_ch.mean_error_ns <= mean_err;
            out_ch.stddev_ns     <= root;
            out_ch.min_error_ns  <= lowest;
            out_ch.max_error_ns  <= highest;
            state                <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
